// ===== src/qrt_pkg.sv =====
`default_nettype none

package qrt_pkg;

  localparam int QUAT_WIDTH   = 16;
  localparam int TERM_WIDTH   = 18;
  localparam int WEIGHT_WIDTH = 32;
  localparam int NUM_TERMS    = 9;
  localparam int REG_IDX_W    = 3;

  // Sum of four quaternion products: 2^32 magnitude at most, with margin.
  localparam int TERM_SUM_W   = 36;

  localparam int DEF_COORD_WIDTH    = 24;
  localparam int DEF_QUAT_FRAC_BITS = 14;

  localparam logic signed [QUAT_WIDTH-1:0] RESET_QUAT_W = 16'sd16384;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_QUAT_W,
    REG_QUAT_X,
    REG_QUAT_Y,
    REG_QUAT_Z,
    REG_OFFSET_X,
    REG_OFFSET_Y,
    REG_OFFSET_Z
  } reg_idx_t;

  typedef enum logic {
    REQ_TO_ZONE,
    REQ_TO_WORLD
  } req_t;

  typedef logic signed [TERM_WIDTH-1:0] term_t;
  typedef term_t [NUM_TERMS-1:0] term_arr_t;

  // Stream payload width: three coordinates and the weight, padded to bytes.
  function automatic int data_width(int cw);
    return ((3 * cw + WEIGHT_WIDTH + 7) / 8) * 8;
  endfunction

  // Rotation terms built from the reset quaternion (pure real part).
  function automatic term_arr_t reset_terms(int qf);
    longint    diag;
    longint    term_max;
    term_arr_t t;
    term_max = (longint'(1) <<< (TERM_WIDTH - 1)) - 1;
    diag = (longint'(RESET_QUAT_W) * longint'(RESET_QUAT_W) + (longint'(1) <<< (qf - 1)))
           >>> qf;
    if (diag > term_max) begin
      diag = term_max;
    end
    t = '0;
    t[0] = TERM_WIDTH'(diag);
    t[4] = TERM_WIDTH'(diag);
    t[8] = TERM_WIDTH'(diag);
    return t;
  endfunction

endpackage

`default_nettype wire

// ===== src/qrt_config_regs.sv =====
`default_nettype none

module qrt_config_regs #(
  parameter int COORD_WIDTH    = qrt_pkg::DEF_COORD_WIDTH,
  parameter int QUAT_FRAC_BITS = qrt_pkg::DEF_QUAT_FRAC_BITS
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_wen,
  input  wire logic [qrt_pkg::REG_IDX_W-1:0]       cfg_addr,
  input  wire logic [COORD_WIDTH-1:0]              cfg_wdata,
  output logic signed [COORD_WIDTH-1:0]            offset_x,
  output logic signed [COORD_WIDTH-1:0]            offset_y,
  output logic signed [COORD_WIDTH-1:0]            offset_z,
  output qrt_pkg::term_arr_t                       terms
);

  import qrt_pkg::*;

  localparam logic signed [TERM_SUM_W-1:0] ROUND_HALF =
    TERM_SUM_W'(1) <<< (QUAT_FRAC_BITS - 1);
  localparam logic signed [TERM_SUM_W-1:0] T_HI = TERM_SUM_W'((1 <<< (TERM_WIDTH - 1)) - 1);
  localparam logic signed [TERM_SUM_W-1:0] T_LO = -TERM_SUM_W'(1 <<< (TERM_WIDTH - 1));

  logic signed [QUAT_WIDTH-1:0] quat_w, quat_x, quat_y, quat_z;
  logic signed [QUAT_WIDTH-1:0] quat_w_next, quat_x_next, quat_y_next, quat_z_next;
  logic signed [2*QUAT_WIDTH-1:0] p_ww, p_xx, p_yy, p_zz;
  logic signed [2*QUAT_WIDTH-1:0] p_xy, p_wz, p_xz, p_wy, p_yz, p_wx;
  logic signed [TERM_SUM_W-1:0] sum [NUM_TERMS];
  logic signed [TERM_SUM_W-1:0] rnd [NUM_TERMS];
  term_arr_t terms_next;

  // Terms follow the quaternion written in this same cycle, so the matrix
  // is valid at the edge that updates the register.
  always_comb begin
    quat_w_next = quat_w;
    quat_x_next = quat_x;
    quat_y_next = quat_y;
    quat_z_next = quat_z;
    if (cfg_wen) begin
      unique case (cfg_addr)
        REG_QUAT_W: quat_w_next = cfg_wdata[QUAT_WIDTH-1:0];
        REG_QUAT_X: quat_x_next = cfg_wdata[QUAT_WIDTH-1:0];
        REG_QUAT_Y: quat_y_next = cfg_wdata[QUAT_WIDTH-1:0];
        REG_QUAT_Z: quat_z_next = cfg_wdata[QUAT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  assign p_ww = quat_w_next * quat_w_next;
  assign p_xx = quat_x_next * quat_x_next;
  assign p_yy = quat_y_next * quat_y_next;
  assign p_zz = quat_z_next * quat_z_next;
  assign p_xy = quat_x_next * quat_y_next;
  assign p_wz = quat_w_next * quat_z_next;
  assign p_xz = quat_x_next * quat_z_next;
  assign p_wy = quat_w_next * quat_y_next;
  assign p_yz = quat_y_next * quat_z_next;
  assign p_wx = quat_w_next * quat_x_next;

  always_comb begin
    sum[0] = TERM_SUM_W'(p_ww) + TERM_SUM_W'(p_xx) - TERM_SUM_W'(p_yy) - TERM_SUM_W'(p_zz);
    sum[1] = (TERM_SUM_W'(p_xy) <<< 1) - (TERM_SUM_W'(p_wz) <<< 1);
    sum[2] = (TERM_SUM_W'(p_xz) <<< 1) + (TERM_SUM_W'(p_wy) <<< 1);
    sum[3] = (TERM_SUM_W'(p_xy) <<< 1) + (TERM_SUM_W'(p_wz) <<< 1);
    sum[4] = TERM_SUM_W'(p_ww) - TERM_SUM_W'(p_xx) + TERM_SUM_W'(p_yy) - TERM_SUM_W'(p_zz);
    sum[5] = (TERM_SUM_W'(p_yz) <<< 1) - (TERM_SUM_W'(p_wx) <<< 1);
    sum[6] = (TERM_SUM_W'(p_xz) <<< 1) - (TERM_SUM_W'(p_wy) <<< 1);
    sum[7] = (TERM_SUM_W'(p_yz) <<< 1) + (TERM_SUM_W'(p_wx) <<< 1);
    sum[8] = TERM_SUM_W'(p_ww) - TERM_SUM_W'(p_xx) - TERM_SUM_W'(p_yy) + TERM_SUM_W'(p_zz);
  end

  // Round half up to the fraction width, then clamp to the term range.
  always_comb begin
    for (int k = 0; k < NUM_TERMS; k++) begin
      rnd[k] = (sum[k] + ROUND_HALF) >>> QUAT_FRAC_BITS;
      if (rnd[k] > T_HI) begin
        terms_next[k] = T_HI[TERM_WIDTH-1:0];
      end else if (rnd[k] < T_LO) begin
        terms_next[k] = T_LO[TERM_WIDTH-1:0];
      end else begin
        terms_next[k] = rnd[k][TERM_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quat_w   <= RESET_QUAT_W;
      quat_x   <= '0;
      quat_y   <= '0;
      quat_z   <= '0;
      offset_x <= '0;
      offset_y <= '0;
      offset_z <= '0;
      terms    <= reset_terms(QUAT_FRAC_BITS);
    end else begin
      quat_w <= quat_w_next;
      quat_x <= quat_x_next;
      quat_y <= quat_y_next;
      quat_z <= quat_z_next;
      terms  <= terms_next;
      if (cfg_wen) begin
        unique case (cfg_addr)
          REG_OFFSET_X: offset_x <= cfg_wdata;
          REG_OFFSET_Y: offset_y <= cfg_wdata;
          REG_OFFSET_Z: offset_z <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/qrt_transform.sv =====
`default_nettype none

module qrt_transform #(
  parameter int COORD_WIDTH    = qrt_pkg::DEF_COORD_WIDTH,
  parameter int QUAT_FRAC_BITS = qrt_pkg::DEF_QUAT_FRAC_BITS
) (
  input  wire logic                         req_type,
  input  wire logic signed [COORD_WIDTH-1:0] pos_x,
  input  wire logic signed [COORD_WIDTH-1:0] pos_y,
  input  wire logic signed [COORD_WIDTH-1:0] pos_z,
  input  wire logic signed [COORD_WIDTH-1:0] offset_x,
  input  wire logic signed [COORD_WIDTH-1:0] offset_y,
  input  wire logic signed [COORD_WIDTH-1:0] offset_z,
  input  wire qrt_pkg::term_arr_t           terms,
  output logic signed [COORD_WIDTH-1:0]     res_x,
  output logic signed [COORD_WIDTH-1:0]     res_y,
  output logic signed [COORD_WIDTH-1:0]     res_z,
  output logic                              clipped
);

  import qrt_pkg::*;

  localparam int OP_W   = COORD_WIDTH + 1;
  localparam int PROD_W = OP_W + TERM_WIDTH;
  localparam int ACC_W  = COORD_WIDTH + 22;

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (QUAT_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] C_HI =
    {{(ACC_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] C_LO =
    {{(ACC_W-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

  logic                          fwd;
  logic signed [COORD_WIDTH-1:0] pos [3];
  logic signed [COORD_WIDTH-1:0] off [3];
  logic signed [OP_W-1:0]        opnd [3];
  term_t                         coef [3][3];
  logic signed [PROD_W-1:0]      prod [3][3];
  logic signed [ACC_W-1:0]       acc [3];
  logic signed [ACC_W-1:0]       rnd [3];
  logic signed [COORD_WIDTH-1:0] res [3];
  logic [2:0]                    hit;

  assign fwd    = (req_t'(req_type) == REQ_TO_ZONE);
  assign pos[0] = pos_x;
  assign pos[1] = pos_y;
  assign pos[2] = pos_z;
  assign off[0] = offset_x;
  assign off[1] = offset_y;
  assign off[2] = offset_z;

  // To zone: translate first, then rotate by the transpose.
  // To world: rotate by the matrix, the offset enters as a scaled bias.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      opnd[j] = fwd ? (OP_W'(pos[j]) - OP_W'(off[j])) : OP_W'(pos[j]);
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        coef[i][j] = fwd ? terms[j*3+i] : terms[i*3+j];
        prod[i][j] = opnd[j] * coef[i][j];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = (fwd ? '0 : (ACC_W'(off[i]) <<< QUAT_FRAC_BITS))
             + ACC_W'(prod[i][0]) + ACC_W'(prod[i][1]) + ACC_W'(prod[i][2]);
      rnd[i] = (acc[i] + ROUND_HALF) >>> QUAT_FRAC_BITS;
      if (rnd[i] > C_HI) begin
        res[i] = C_HI[COORD_WIDTH-1:0];
        hit[i] = 1'b1;
      end else if (rnd[i] < C_LO) begin
        res[i] = C_LO[COORD_WIDTH-1:0];
        hit[i] = 1'b1;
      end else begin
        res[i] = rnd[i][COORD_WIDTH-1:0];
        hit[i] = 1'b0;
      end
    end
  end

  assign res_x   = res[0];
  assign res_y   = res[1];
  assign res_z   = res[2];
  assign clipped = |hit;

endmodule

`default_nettype wire

// ===== src/quaternion_rigid_transform_core.sv =====
// Rigid transform of 3D points by a configured quaternion and translation.
//
// Input stream (s_axis_*): one transaction carries one point, its weight
// and the direction in tuser (0 world to zone, 1 zone to world).
// Output stream (m_axis_*): one transaction per input point, with the
// rounded, saturated coordinates, the unchanged weight and a clip flag.
// Configuration: write cfg_wdata to register cfg_addr while cfg_wen is
// high (0..3 quaternion w, x, y, z; 4..6 offset x, y, z; 7 ignored).
// Write only while no transaction is in flight. The rotation matrix is
// rebuilt in the same cycle as a quaternion write, so a point may follow
// on the very next cycle.
// Throughput: one point per cycle, sustained while m_axis_tready is high.
// A point passes through the input register and then the result register;
// the input register and the result register bound a single combinational
// pass of nine multiplies.
// Reset: identity rotation, zero offset, both stages empty.
// Stall: while m_axis_tready is low the result register holds and the
// input register can still take one more point; tready drops only when
// both are full.

`default_nettype none

module quaternion_rigid_transform_core #(
  parameter int COORD_WIDTH    = qrt_pkg::DEF_COORD_WIDTH,
  parameter int QUAT_FRAC_BITS = qrt_pkg::DEF_QUAT_FRAC_BITS
) (
  input  wire logic                                          clk,
  input  wire logic                                          rst,
  // configuration write port
  input  wire logic                                          cfg_wen,
  input  wire logic [qrt_pkg::REG_IDX_W-1:0]                 cfg_addr,
  input  wire logic [COORD_WIDTH-1:0]                        cfg_wdata,
  // input stream
  input  wire logic                                          s_axis_tvalid,
  output logic                                               s_axis_tready,
  // tdata, from bit 0: pos_x, pos_y, pos_z, weight, zero fill
  input  wire logic [qrt_pkg::data_width(COORD_WIDTH)-1:0]  s_axis_tdata,
  // tuser: req_type
  input  wire logic                                          s_axis_tuser,
  // output stream
  output logic                                               m_axis_tvalid,
  input  wire logic                                          m_axis_tready,
  // tdata, from bit 0: res_x, res_y, res_z, res_weight, zero fill
  output logic [qrt_pkg::data_width(COORD_WIDTH)-1:0]       m_axis_tdata,
  // tuser: clipped
  output logic                                               m_axis_tuser
);

  import qrt_pkg::*;

  localparam int DATA_W = data_width(COORD_WIDTH);
  localparam int CW     = COORD_WIDTH;

  // configuration and rotation matrix
  logic signed [CW-1:0] offset_x, offset_y, offset_z;
  term_arr_t            terms;

  // input stage
  logic                 in_valid, in_valid_next;
  logic                 in_req;
  logic signed [CW-1:0] in_x, in_y, in_z;
  logic [WEIGHT_WIDTH-1:0] in_weight;

  // combinational results
  logic signed [CW-1:0] calc_x, calc_y, calc_z;
  logic                 calc_clipped;

  // result stage
  logic                 out_valid, out_valid_next;
  logic signed [CW-1:0] out_x, out_y, out_z;
  logic [WEIGHT_WIDTH-1:0] out_weight;
  logic                 out_clipped;

  logic s_accept;
  logic advance;

  qrt_config_regs #(
    .COORD_WIDTH   (COORD_WIDTH),
    .QUAT_FRAC_BITS(QUAT_FRAC_BITS)
  ) u_config_regs (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .offset_x (offset_x),
    .offset_y (offset_y),
    .offset_z (offset_z),
    .terms    (terms)
  );

  // Advance the pipeline whenever the result register is empty or drained.
  assign advance       = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_next = in_valid;
    if (s_accept) begin
      in_valid_next = 1'b1;
    end else if (advance) begin
      in_valid_next = 1'b0;
    end
  end

  assign out_valid_next = advance ? in_valid : out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      in_valid  <= in_valid_next;
      out_valid <= out_valid_next;
    end
  end

  // Capture the point on each input transaction.
  always_ff @(posedge clk) begin
    if (s_accept) begin
      in_req    <= s_axis_tuser;
      in_x      <= s_axis_tdata[CW-1:0];
      in_y      <= s_axis_tdata[2*CW-1:CW];
      in_z      <= s_axis_tdata[3*CW-1:2*CW];
      in_weight <= s_axis_tdata[3*CW+WEIGHT_WIDTH-1:3*CW];
    end
  end

  qrt_transform #(
    .COORD_WIDTH   (COORD_WIDTH),
    .QUAT_FRAC_BITS(QUAT_FRAC_BITS)
  ) u_transform (
    .req_type(in_req),
    .pos_x   (in_x),
    .pos_y   (in_y),
    .pos_z   (in_z),
    .offset_x(offset_x),
    .offset_y(offset_y),
    .offset_z(offset_z),
    .terms   (terms),
    .res_x   (calc_x),
    .res_y   (calc_y),
    .res_z   (calc_z),
    .clipped (calc_clipped)
  );

  // Hold the result while the receiver stalls.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_x       <= calc_x;
      out_y       <= calc_y;
      out_z       <= calc_z;
      out_weight  <= in_weight;
      out_clipped <= calc_clipped;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = DATA_W'({out_weight, out_z, out_y, out_x});
  assign m_axis_tuser  = out_clipped;

  // Reset leaves the identity rotation in the matrix register.
  a_reset_terms: assert property (@(posedge clk)
    rst |=> (terms == reset_terms(QUAT_FRAC_BITS)))
    else $error("rotation terms not at identity after reset");

  // A pending point stays in the input stage while the output is blocked.
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> in_valid)
    else $error("input stage dropped a point during a stall");

  // Back-pressure only when both stages are full and the receiver stalls.
  a_ready_reason: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (in_valid && out_valid && !m_axis_tready))
    else $error("tready low with free room in the pipeline");

  // A result is presented in the cycle after its point left the input stage.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (in_valid && advance) |=> out_valid)
    else $error("point left the input stage without a result");

endmodule

`default_nettype wire
